// File: src/dgcd_pkg.sv
// Shared types and constants for the directed graph cycle detector.
// No dependencies; imported by dgcd_vertex_ram and the top level.
package dgcd_pkg;

    localparam int VTX_W = 6;                  // width of edge_src / edge_dst
    localparam int NV_W  = 7;                  // width of num_vertices
    localparam logic [NV_W-1:0] NV_RESET = 7'd64;

    // per-vertex marks kept next to the adjacency list head
    typedef struct packed {
        logic on_path;
        logic visited;
    } vtx_flags_t;

endpackage

// File: src/directed_graph_cycle_detect.sv
// Directed graph cycle detector: loads edges, then DFS with an explicit stack.
// Load: each item takes a vertex table read, then an edge/head write, before the next.
// Search after the last item: root probe reads vertex table; followed edge reads edge
// store, then target marks; pop reads stack. Answer strobes once on done, then sweep.
// Reset (rst_n low, async) starts the same table sweep; busy stays high.
// Results cannot be stalled; done is high for exactly one cycle.
module directed_graph_cycle_detect #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dgcd_pkg::VTX_W-1:0] edge_src,
    input  logic [dgcd_pkg::VTX_W-1:0] edge_dst,
    input  logic                       edge_valid,
    input  logic                       last_edge,
    output logic                       done,
    output logic                       cycle_found,
    output logic                       edges_dropped,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dgcd_pkg::NV_W-1:0]  cfg_data
);
    import dgcd_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int LW = $clog2(MAX_VERTICES + 1);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [EW-1:0] NULL_PTR = EW'(MAX_EDGES);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LOAD     = 4'd2;
    localparam logic [3:0] S_ROOT     = 4'd3;
    localparam logic [3:0] S_ROOT_CHK = 4'd4;
    localparam logic [3:0] S_STEP     = 4'd5;
    localparam logic [3:0] S_POP_WAIT = 4'd6;
    localparam logic [3:0] S_EDGE_RD  = 4'd7;
    localparam logic [3:0] S_TGT_CHK  = 4'd8;

    logic [3:0]      state_reg,   state_next;
    logic [NV_W-1:0] nv_reg,      nv_next;
    logic [EW-1:0]   count_reg,   count_next;
    logic            drop_reg,    drop_next;
    logic [VW-1:0]   src_reg,     src_next;
    logic [VW-1:0]   dst_reg,     dst_next;
    logic            store_reg,   store_next;
    logic            last_reg,    last_next;
    logic [LW-1:0]   root_reg,    root_next;
    logic [LW-1:0]   level_reg,   level_next;
    logic [VW-1:0]   top_v_reg,   top_v_next;
    logic [EW-1:0]   top_ptr_reg, top_ptr_next;
    logic [VW-1:0]   tgt_reg,     tgt_next;
    logic [VW-1:0]   clr_reg,     clr_next;
    logic            done_reg,    done_next;
    logic            found_reg,   found_next;
    logic            dropped_reg, dropped_next;

    // vertex table port signals
    logic            v_wr_en, v_rd_en;
    logic [VW-1:0]   v_wr_addr, v_rd_addr;
    vtx_flags_t      v_wr_flags, v_rd_flags;
    logic [EW-1:0]   v_wr_head, v_rd_head;
    // edge store: {target, link}
    logic            e_wr_en, e_rd_en;
    logic [AW-1:0]   e_wr_addr, e_rd_addr;
    logic [VW+EW-1:0] e_wr_data, e_rd_data;
    // frame stack: {vertex, next edge}; holds all frames below the top one
    logic            s_wr_en, s_rd_en;
    logic [VW-1:0]   s_wr_addr, s_rd_addr;
    logic [VW+EW-1:0] s_wr_data, s_rd_data;

    logic [LW-1:0]   limit;
    logic [LW-1:0]   lvl_m1, lvl_m2;
    logic            accept, edge_ok;

    always_comb
    begin
        if (32'(nv_reg) > MAX_VERTICES)
        begin
            limit = LW'(MAX_VERTICES);
        end
        else
        begin
            limit = LW'(nv_reg);
        end
    end

    assign accept  = start && (state_reg == S_IDLE);
    assign edge_ok = edge_valid && (32'(edge_src) < 32'(limit))
                     && (32'(edge_dst) < 32'(limit)) && (count_reg != NULL_PTR);
    assign lvl_m1  = level_reg - LW'(1);
    assign lvl_m2  = level_reg - LW'(2);

    always_comb
    begin
        state_next   = state_reg;
        nv_next      = nv_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        store_next   = store_reg;
        last_next    = last_reg;
        root_next    = root_reg;
        level_next   = level_reg;
        top_v_next   = top_v_reg;
        top_ptr_next = top_ptr_reg;
        tgt_next     = tgt_reg;
        clr_next     = clr_reg;
        done_next    = 1'b0;
        found_next   = found_reg;
        dropped_next = dropped_reg;

        v_wr_en    = 1'b0;
        v_wr_addr  = '0;
        v_wr_flags = '0;
        v_wr_head  = NULL_PTR;
        v_rd_en    = 1'b0;
        v_rd_addr  = '0;
        e_wr_en    = 1'b0;
        e_wr_addr  = count_reg[AW-1:0];
        e_wr_data  = {dst_reg, v_rd_head};
        e_rd_en    = 1'b0;
        e_rd_addr  = top_ptr_reg[AW-1:0];
        s_wr_en    = 1'b0;
        s_wr_addr  = lvl_m1[VW-1:0];
        s_wr_data  = {top_v_reg, top_ptr_reg};
        s_rd_en    = 1'b0;
        s_rd_addr  = lvl_m2[VW-1:0];

        if (cfg_valid && cfg_ready)
        begin
            nv_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                v_wr_en   = 1'b1;
                v_wr_addr = clr_reg;
                clr_next  = clr_reg + VW'(1);
                if (clr_reg == VW'(MAX_VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    src_next   = VW'(edge_src);
                    dst_next   = VW'(edge_dst);
                    store_next = edge_ok;
                    last_next  = last_edge;
                    drop_next  = drop_reg | (edge_valid & ~edge_ok);
                    v_rd_en    = 1'b1;
                    v_rd_addr  = VW'(edge_src);
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // prepend the edge to the source vertex's list
                if (store_reg)
                begin
                    e_wr_en    = 1'b1;
                    v_wr_en    = 1'b1;
                    v_wr_addr  = src_reg;
                    v_wr_head  = count_reg;
                    count_next = count_reg + EW'(1);
                end
                if (last_reg)
                begin
                    root_next  = '0;
                    state_next = S_ROOT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (root_reg >= limit)
                begin
                    done_next    = 1'b1;
                    found_next   = 1'b0;
                    dropped_next = drop_reg;
                    count_next   = '0;
                    drop_next    = 1'b0;
                    level_next   = '0;
                    clr_next     = '0;
                    state_next   = S_CLEAR;
                end
                else
                begin
                    v_rd_en    = 1'b1;
                    v_rd_addr  = root_reg[VW-1:0];
                    state_next = S_ROOT_CHK;
                end
            end
            S_ROOT_CHK:
            begin
                root_next = root_reg + LW'(1);
                if (v_rd_flags.visited)
                begin
                    state_next = S_ROOT;
                end
                else
                begin
                    v_wr_en      = 1'b1;
                    v_wr_addr    = root_reg[VW-1:0];
                    v_wr_flags   = '{on_path: 1'b1, visited: 1'b1};
                    v_wr_head    = v_rd_head;
                    top_v_next   = root_reg[VW-1:0];
                    top_ptr_next = v_rd_head;
                    level_next   = LW'(1);
                    state_next   = S_STEP;
                end
            end
            S_STEP:
            begin
                if (top_ptr_reg >= count_reg)
                begin
                    // list exhausted: leave the path and pop the frame
                    v_wr_en    = 1'b1;
                    v_wr_addr  = top_v_reg;
                    v_wr_flags = '{on_path: 1'b0, visited: 1'b1};
                    level_next = lvl_m1;
                    if (level_reg > LW'(1))
                    begin
                        s_rd_en    = 1'b1;
                        state_next = S_POP_WAIT;
                    end
                    else
                    begin
                        state_next = S_ROOT;
                    end
                end
                else
                begin
                    e_rd_en    = 1'b1;
                    state_next = S_EDGE_RD;
                end
            end
            S_POP_WAIT:
            begin
                top_v_next   = s_rd_data[VW+EW-1:EW];
                top_ptr_next = s_rd_data[EW-1:0];
                state_next   = S_STEP;
            end
            S_EDGE_RD:
            begin
                top_ptr_next = e_rd_data[EW-1:0];
                tgt_next     = e_rd_data[VW+EW-1:EW];
                v_rd_en      = 1'b1;
                v_rd_addr    = e_rd_data[VW+EW-1:EW];
                state_next   = S_TGT_CHK;
            end
            S_TGT_CHK:
            begin
                if (!v_rd_flags.visited)
                begin
                    s_wr_en      = 1'b1;
                    v_wr_en      = 1'b1;
                    v_wr_addr    = tgt_reg;
                    v_wr_flags   = '{on_path: 1'b1, visited: 1'b1};
                    v_wr_head    = v_rd_head;
                    top_v_next   = tgt_reg;
                    top_ptr_next = v_rd_head;
                    level_next   = level_reg + LW'(1);
                    state_next   = S_STEP;
                end
                else if (v_rd_flags.on_path)
                begin
                    // back edge
                    done_next    = 1'b1;
                    found_next   = 1'b1;
                    dropped_next = drop_reg;
                    count_next   = '0;
                    drop_next    = 1'b0;
                    level_next   = '0;
                    clr_next     = '0;
                    state_next   = S_CLEAR;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            default:
            begin
                clr_next   = '0;
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            nv_reg    <= NV_RESET;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            level_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nv_reg    <= nv_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            level_reg <= level_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        store_reg   <= store_next;
        last_reg    <= last_next;
        root_reg    <= root_next;
        top_v_reg   <= top_v_next;
        top_ptr_reg <= top_ptr_next;
        tgt_reg     <= tgt_next;
        found_reg   <= found_next;
        dropped_reg <= dropped_next;
    end

    dgcd_vertex_ram #(
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (VW),
        .HEAD_W (EW)
    ) u_vertex (
        .clk      (clk),
        .wr_en    (v_wr_en),
        .wr_addr  (v_wr_addr),
        .wr_flags (v_wr_flags),
        .wr_head  (v_wr_head),
        .rd_en    (v_rd_en),
        .rd_addr  (v_rd_addr),
        .rd_flags (v_rd_flags),
        .rd_head  (v_rd_head)
    );

    dgcd_ram #(
        .WIDTH  (VW + EW),
        .DEPTH  (MAX_EDGES),
        .ADDR_W (AW)
    ) u_edges (
        .clk     (clk),
        .wr_en   (e_wr_en),
        .wr_addr (e_wr_addr),
        .wr_data (e_wr_data),
        .rd_en   (e_rd_en),
        .rd_addr (e_rd_addr),
        .rd_data (e_rd_data)
    );

    dgcd_ram #(
        .WIDTH  (VW + EW),
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (VW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (s_wr_en),
        .wr_addr (s_wr_addr),
        .wr_data (s_wr_data),
        .rd_en   (s_rd_en),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data)
    );

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign cycle_found   = found_reg;
    assign edges_dropped = dropped_reg;

`ifndef SYNTHESIS
    a_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("answer strobed outside the clearing sweep");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not enter the load step");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(MAX_VERTICES))
        else $error("DFS stack depth beyond vertex count");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NULL_PTR)
        else $error("edge count beyond store capacity");
`endif

endmodule

// File: src/dgcd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; holds the edge store and the DFS frame stack.
module dgcd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/dgcd_vertex_ram.sv
// Vertex table: adjacency list head plus visited / on-path marks per vertex.
// Depends on dgcd_pkg for the mark record.
module dgcd_vertex_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int HEAD_W = 9
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  dgcd_pkg::vtx_flags_t wr_flags,
    input  logic [HEAD_W-1:0]    wr_head,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output dgcd_pkg::vtx_flags_t rd_flags,
    output logic [HEAD_W-1:0]    rd_head
);
    import dgcd_pkg::*;

    vtx_flags_t        flags_mem [DEPTH];
    logic [HEAD_W-1:0] head_mem  [DEPTH];
    vtx_flags_t        rd_flags_reg;
    logic [HEAD_W-1:0] rd_head_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flags_mem[wr_addr] <= wr_flags;
            head_mem[wr_addr]  <= wr_head;
        end
        if (rd_en)
        begin
            rd_flags_reg <= flags_mem[rd_addr];
            rd_head_reg  <= head_mem[rd_addr];
        end
    end

    assign rd_flags = rd_flags_reg;
    assign rd_head  = rd_head_reg;

endmodule
